@@ hw/rtl/ethl4p_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet / IP / L4 header parser package
// Shared constants for the byte-serial header parser: sizes, register
// indexes, ethertypes, IP protocol numbers and record kind codes.
// ----------------------------------------------------------------------------
package ethl4p_pkg;

  localparam int unsigned MaxFrameBytes = 16384;
  localparam int unsigned PosW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned PayOffW       = PosW + 1;
  localparam int unsigned NumKinds      = 15;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgVlanTypeA = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgVlanTypeB = 1'b1;

  localparam logic [15:0] VlanTypeAReset = 16'h8100;
  localparam logic [15:0] VlanTypeBReset = 16'h88A8;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeIpv6 = 16'h86DD;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic [5:0] UdpHdrBytes = 6'd8;
  localparam logic [3:0] Ipv4MinIhl  = 4'd5;
  localparam logic [2:0] IpVer4      = 3'd4;
  localparam logic [2:0] IpVer6      = 3'd6;

  localparam logic [3:0] KindDmac     = 4'd0;
  localparam logic [3:0] KindSmac     = 4'd1;
  localparam logic [3:0] KindEtype    = 4'd2;
  localparam logic [3:0] KindIpVer    = 4'd3;
  localparam logic [3:0] KindProto    = 4'd4;
  localparam logic [3:0] KindSrcHi    = 4'd5;
  localparam logic [3:0] KindSrcLo    = 4'd6;
  localparam logic [3:0] KindDstHi    = 4'd7;
  localparam logic [3:0] KindDstLo    = 4'd8;
  localparam logic [3:0] KindSrcPort  = 4'd9;
  localparam logic [3:0] KindDstPort  = 4'd10;
  localparam logic [3:0] KindFlags    = 4'd11;
  localparam logic [3:0] KindPayOff   = 4'd12;
  localparam logic [3:0] KindPayLen   = 4'd13;
  localparam logic [3:0] KindStatus   = 4'd14;

endpackage

@@ hw/rtl/eth_ip_l4_header_parser_core.sv @@
// ----------------------------------------------------------------------------
// Ethernet / VLAN / IPv4 / IPv6 / TCP / UDP header parser
// Parses one frame byte per beat and, on the last byte, emits the captured
// header fields as records followed by a status record.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  frame_byte_i, frame_end_i
//  out      output     out_valid_o/out_stall_i record_kind_o, record_value_o,
//                                              last_record_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One byte is taken every cycle, but a last byte is stalled only while the
//  bank still holds records; the parse step sits between parser registers.
//  On the last byte the fields move to a record bank, which drains one
//  record per unstalled cycle (1 to 15 records) while the next frame is parsed.
//  Reset restores the VLAN ethertypes and clears parser, bank and output.
// ----------------------------------------------------------------------------
module eth_ip_l4_header_parser_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           frame_byte_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [3:0]                           record_kind_o,
  output logic [63:0]                          record_value_o,
  output logic                                 last_record_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ethl4p_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ethl4p_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    PhEth, PhVlan, PhIpv4, PhIpv6, PhTcp, PhUdp, PhIpBad,
    PhDoneNoIp, PhDoneIp, PhDoneL4
  } phase_e;

  localparam int unsigned PosW = ethl4p_pkg::PosW;
  localparam int unsigned PayW = ethl4p_pkg::PayOffW;
  localparam int unsigned NK   = ethl4p_pkg::NumKinds;

  // config
  logic [15:0] vlan_a_q, vlan_b_q;

  // parser state
  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] ls_q, ls_d;
  logic [47:0]     dmac_q, dmac_d, smac_q, smac_d;
  logic [15:0]     etype_q, etype_d;
  logic [5:0]      ihb_q, ihb_d, thb_q, thb_d;
  logic [2:0]      ipver_q, ipver_d;
  logic [7:0]      proto_q, proto_d, flags_q, flags_d;
  logic [63:0]     src0_q, src0_d, src1_q, src1_d, dst0_q, dst0_d, dst1_q, dst1_d;
  logic [15:0]     port0_q, port0_d, port1_q, port1_d;

  logic [PosW-1:0] rel;
  logic            take;
  logic            in_acc, frame_done;

  // record bank
  logic [NK-1:0]   mask_q, mask_d, mask_new, mask_eff, pick;
  logic [47:0]     b_dmac_q, b_smac_q;
  logic [15:0]     b_etype_q, b_port0_q, b_port1_q;
  logic [2:0]      b_ipver_q;
  logic [7:0]      b_proto_q, b_flags_q;
  logic [63:0]     b_src0_q, b_src1_q, b_dst0_q, b_dst1_q;
  logic [PosW-1:0] b_ls_q, b_len_q;
  logic [5:0]      b_thb_q;
  logic            b_fail_q, fail_new;
  logic [PayW-1:0] payoff_q;
  logic [PosW-1:0] paylen_q;
  logic            pay_ok_q;
  logic [PayW-1:0] payoff_c;
  logic            bank_busy, emit;
  logic [3:0]      pick_kind;
  logic [63:0]     pick_value;

  // output register
  logic            out_valid_q;
  logic [3:0]      kind_q;
  logic [63:0]     value_q;
  logic            last_q;

  function automatic logic is_vlan(input logic [15:0] t, input logic [15:0] a,
                                   input logic [15:0] b);
    return (t == a) || (t == b);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign bank_busy   = |mask_q;
  assign in_stall_o  = frame_end_i && bank_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign frame_done  = in_acc && frame_end_i;

  // parse step for one byte
  always_comb begin
    phase_d = phase_q;  pos_d   = pos_q;   ls_d    = ls_q;
    dmac_d  = dmac_q;   smac_d  = smac_q;  etype_d = etype_q;
    ihb_d   = ihb_q;    thb_d   = thb_q;   ipver_d = ipver_q;
    proto_d = proto_q;  flags_d = flags_q;
    src0_d  = src0_q;   src1_d  = src1_q;  dst0_d  = dst0_q;  dst1_d = dst1_q;
    port0_d = port0_q;  port1_d = port1_q;
    rel  = pos_q - ls_q;
    take = pos_q < PosW'(ethl4p_pkg::MaxFrameBytes);
    if (take) begin
      pos_d = pos_q + PosW'(1);
      case (phase_q)
        PhEth: begin
          if (pos_q < PosW'(6)) begin
            dmac_d = {dmac_q[39:0], frame_byte_i};
          end else if (pos_q < PosW'(12)) begin
            smac_d = {smac_q[39:0], frame_byte_i};
          end else begin
            etype_d = {etype_q[7:0], frame_byte_i};
          end
          if (pos_q == PosW'(13)) begin
            ls_d = PosW'(14);
            if (is_vlan(etype_d, vlan_a_q, vlan_b_q)) begin
              phase_d = PhVlan;
            end else if (etype_d == ethl4p_pkg::EtypeIpv4) begin
              phase_d = PhIpv4;
              ipver_d = ethl4p_pkg::IpVer4;
            end else if (etype_d == ethl4p_pkg::EtypeIpv6) begin
              phase_d = PhIpv6;
              ipver_d = ethl4p_pkg::IpVer6;
            end else begin
              phase_d = PhDoneNoIp;
            end
          end
        end
        PhVlan: begin
          if (rel >= PosW'(2)) etype_d = {etype_q[7:0], frame_byte_i};
          if (rel == PosW'(3)) begin
            ls_d = pos_q + PosW'(1);
            if (is_vlan(etype_d, vlan_a_q, vlan_b_q)) begin
              phase_d = PhVlan;
            end else if (etype_d == ethl4p_pkg::EtypeIpv4) begin
              phase_d = PhIpv4;
              ipver_d = ethl4p_pkg::IpVer4;
            end else if (etype_d == ethl4p_pkg::EtypeIpv6) begin
              phase_d = PhIpv6;
              ipver_d = ethl4p_pkg::IpVer6;
            end else begin
              phase_d = PhDoneNoIp;
            end
          end
        end
        PhIpv4: begin
          if (rel == PosW'(0)) begin
            ihb_d = {frame_byte_i[3:0], 2'b00};
            if (frame_byte_i[3:0] < ethl4p_pkg::Ipv4MinIhl) phase_d = PhIpBad;
          end else if (rel == PosW'(9)) begin
            proto_d = frame_byte_i;
          end else if (rel >= PosW'(12) && rel < PosW'(16)) begin
            src1_d = {32'd0, src1_q[23:0], frame_byte_i};
          end else if (rel >= PosW'(16) && rel < PosW'(20)) begin
            dst1_d = {32'd0, dst1_q[23:0], frame_byte_i};
          end
          if (phase_d != PhIpBad && (rel + PosW'(1)) == PosW'(ihb_d)) begin
            ls_d = pos_q + PosW'(1);
            if (proto_d == ethl4p_pkg::ProtoTcp) begin
              phase_d = PhTcp;
            end else if (proto_d == ethl4p_pkg::ProtoUdp) begin
              phase_d = PhUdp;
              thb_d   = ethl4p_pkg::UdpHdrBytes;
            end else begin
              phase_d = PhDoneIp;
            end
          end
        end
        PhIpv6: begin
          if (rel == PosW'(6)) begin
            proto_d = frame_byte_i;
          end else if (rel >= PosW'(8) && rel < PosW'(16)) begin
            src0_d = {src0_q[55:0], frame_byte_i};
          end else if (rel >= PosW'(16) && rel < PosW'(24)) begin
            src1_d = {src1_q[55:0], frame_byte_i};
          end else if (rel >= PosW'(24) && rel < PosW'(32)) begin
            dst0_d = {dst0_q[55:0], frame_byte_i};
          end else if (rel >= PosW'(32) && rel < PosW'(40)) begin
            dst1_d = {dst1_q[55:0], frame_byte_i};
          end
          if (rel == PosW'(39)) begin
            ls_d = pos_q + PosW'(1);
            if (proto_d == ethl4p_pkg::ProtoTcp) begin
              phase_d = PhTcp;
            end else if (proto_d == ethl4p_pkg::ProtoUdp) begin
              phase_d = PhUdp;
              thb_d   = ethl4p_pkg::UdpHdrBytes;
            end else begin
              phase_d = PhDoneIp;
            end
          end
        end
        PhTcp, PhUdp: begin
          if (rel < PosW'(2)) begin
            port0_d = {port0_q[7:0], frame_byte_i};
          end else if (rel < PosW'(4)) begin
            port1_d = {port1_q[7:0], frame_byte_i};
          end else if (phase_q == PhTcp && rel == PosW'(12)) begin
            thb_d = {frame_byte_i[7:4], 2'b00};
          end else if (phase_q == PhTcp && rel == PosW'(13)) begin
            flags_d = frame_byte_i;
          end
          if ((phase_q == PhTcp && rel == PosW'(19)) ||
              (phase_q == PhUdp && rel == PosW'(7))) begin
            phase_d = PhDoneL4;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // record selection for the closing frame
  always_comb begin
    mask_new = '0;
    fail_new = 1'b1;
    mask_new[ethl4p_pkg::KindStatus] = 1'b1;
    case (phase_d)
      PhVlan: begin
        mask_new[ethl4p_pkg::KindDmac] = 1'b1;
        mask_new[ethl4p_pkg::KindSmac] = 1'b1;
      end
      PhIpv4, PhIpv6, PhIpBad, PhDoneNoIp: begin
        mask_new[ethl4p_pkg::KindEtype:ethl4p_pkg::KindDmac] = '1;
        fail_new = (phase_d != PhDoneNoIp);
      end
      PhTcp, PhUdp, PhDoneIp: begin
        mask_new[ethl4p_pkg::KindDstLo:ethl4p_pkg::KindDmac] = '1;
        fail_new = (phase_d != PhDoneIp);
      end
      PhDoneL4: begin
        mask_new[ethl4p_pkg::KindDstPort:ethl4p_pkg::KindDmac] = '1;
        mask_new[ethl4p_pkg::KindFlags]  = (proto_d == ethl4p_pkg::ProtoTcp);
        mask_new[ethl4p_pkg::KindPayOff] = 1'b1;
        mask_new[ethl4p_pkg::KindPayLen] = 1'b1;
        fail_new = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhEth;  pos_q <= '0;  ls_q <= '0;
      dmac_q <= '0;  smac_q <= '0;  etype_q <= '0;
      ihb_q <= '0;  thb_q <= '0;  ipver_q <= '0;  proto_q <= '0;  flags_q <= '0;
      src0_q <= '0;  src1_q <= '0;  dst0_q <= '0;  dst1_q <= '0;
      port0_q <= '0;  port1_q <= '0;
      vlan_a_q <= ethl4p_pkg::VlanTypeAReset;
      vlan_b_q <= ethl4p_pkg::VlanTypeBReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ethl4p_pkg::CfgVlanTypeA: vlan_a_q <= cfg_data_i;
          ethl4p_pkg::CfgVlanTypeB: vlan_b_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (frame_done) begin
        phase_q <= PhEth;  pos_q <= '0;  ls_q <= '0;
        dmac_q <= '0;  smac_q <= '0;  etype_q <= '0;
        ihb_q <= '0;  thb_q <= '0;  ipver_q <= '0;  proto_q <= '0;  flags_q <= '0;
        src0_q <= '0;  src1_q <= '0;  dst0_q <= '0;  dst1_q <= '0;
        port0_q <= '0;  port1_q <= '0;
      end else if (in_acc) begin
        phase_q <= phase_d;  pos_q <= pos_d;  ls_q <= ls_d;
        dmac_q <= dmac_d;  smac_q <= smac_d;  etype_q <= etype_d;
        ihb_q <= ihb_d;  thb_q <= thb_d;  ipver_q <= ipver_d;
        proto_q <= proto_d;  flags_q <= flags_d;
        src0_q <= src0_d;  src1_q <= src1_d;  dst0_q <= dst0_d;  dst1_q <= dst1_d;
        port0_q <= port0_d;  port1_q <= port1_d;
      end
    end
  end

  // bank payload, loaded on the last byte
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      b_dmac_q <= dmac_d;  b_smac_q <= smac_d;  b_etype_q <= etype_d;
      b_ipver_q <= ipver_d;  b_proto_q <= proto_d;  b_flags_q <= flags_d;
      b_src0_q <= src0_d;  b_src1_q <= src1_d;  b_dst0_q <= dst0_d;  b_dst1_q <= dst1_d;
      b_port0_q <= port0_d;  b_port1_q <= port1_d;
      b_ls_q <= ls_d;  b_thb_q <= thb_d;  b_len_q <= pos_d;  b_fail_q <= fail_new;
    end
    // payload records come after the port records, so the registered offset and length are ready in time
    payoff_q <= payoff_c;
    pay_ok_q <= PayW'(b_len_q) > payoff_c;
    paylen_q <= b_len_q - payoff_c[PosW-1:0];
  end

  assign payoff_c = PayW'(b_ls_q) + PayW'(b_thb_q);

  // lowest pending record
  always_comb begin
    mask_eff = mask_q;
    if (!pay_ok_q) begin
      mask_eff[ethl4p_pkg::KindPayOff] = 1'b0;
      mask_eff[ethl4p_pkg::KindPayLen] = 1'b0;
    end
    pick      = mask_eff & (~mask_eff + NK'(1));
    pick_kind = '0;
    for (int k = 0; k < NK; k++) begin
      if (pick[k]) pick_kind = 4'(k);
    end
    mask_d = mask_q & ~(pick | (pick - NK'(1)));
    case (pick_kind)
      ethl4p_pkg::KindDmac:    pick_value = {16'd0, b_dmac_q};
      ethl4p_pkg::KindSmac:    pick_value = {16'd0, b_smac_q};
      ethl4p_pkg::KindEtype:   pick_value = {48'd0, b_etype_q};
      ethl4p_pkg::KindIpVer:   pick_value = {61'd0, b_ipver_q};
      ethl4p_pkg::KindProto:   pick_value = {56'd0, b_proto_q};
      ethl4p_pkg::KindSrcHi:   pick_value = b_src0_q;
      ethl4p_pkg::KindSrcLo:   pick_value = b_src1_q;
      ethl4p_pkg::KindDstHi:   pick_value = b_dst0_q;
      ethl4p_pkg::KindDstLo:   pick_value = b_dst1_q;
      ethl4p_pkg::KindSrcPort: pick_value = {48'd0, b_port0_q};
      ethl4p_pkg::KindDstPort: pick_value = {48'd0, b_port1_q};
      ethl4p_pkg::KindFlags:   pick_value = {56'd0, b_flags_q};
      ethl4p_pkg::KindPayOff:  pick_value = 64'(payoff_q);
      ethl4p_pkg::KindPayLen:  pick_value = 64'(paylen_q);
      ethl4p_pkg::KindStatus:  pick_value = {63'd0, b_fail_q};
      default:                 pick_value = '0;
    endcase
  end

  assign emit = (|mask_eff) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (frame_done) begin
        mask_q <= mask_new;
      end else if (emit) begin
        mask_q <= mask_d;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= pick_kind;
      value_q <= pick_value;
      last_q  <= (pick_kind == ethl4p_pkg::KindStatus);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = kind_q;
  assign record_value_o = value_q;
  assign last_record_o  = last_q;

  a_bank_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_busy |-> mask_q[ethl4p_pkg::KindStatus])
    else $error("record bank holds records without a status record");

  a_bank_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> mask_q[ethl4p_pkg::KindStatus])
    else $error("last byte did not load the record bank");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_record_o |-> record_kind_o == ethl4p_pkg::KindStatus)
    else $error("last record flag on a non-status record");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(ethl4p_pkg::MaxFrameBytes))
    else $error("byte position past frame limit");

  a_eth_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhEth |-> pos_q < PosW'(14))
    else $error("still in ethernet header past its length");

endmodule
